/* rtl/tss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two stacks in one store: shared package
// Request and status codes, the controller state and the control structs
// passed between the controller and the top level.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef logic [1:0] tss_kind_t;
  localparam tss_kind_t KIND_PUSH = 2'd0;
  localparam tss_kind_t KIND_POP  = 2'd1;
  localparam tss_kind_t KIND_PEEK = 2'd2;

  typedef logic [1:0] tss_status_t;
  localparam tss_status_t STAT_OK    = 2'd0;
  localparam tss_status_t STAT_FULL  = 2'd1;
  localparam tss_status_t STAT_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_READ
  } tss_state_t;

  // Memory strobes from the controller.
  typedef struct packed {
    logic we;
    logic re;
  } tss_mem_req_t;

  // Result register control from the controller.
  typedef struct packed {
    logic        load;
    logic        from_mem;
    tss_status_t status;
  } tss_out_ctl_t;

endpackage

/* rtl/two_stacks_shared_array_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two stacks in one store
// Top level: two LIFO stacks sharing one word memory, with a result register.
// ----------------------------------------------------------------------------
// Two LIFO stacks share one memory of DEPTH 32-bit words: the lower stack
// fills slots upward from slot 0 and the upper stack fills slots downward from
// slot DEPTH-1. Each request transfer names a stack and a push, pop or peek,
// and yields exactly one result transfer carrying the read value and a status
// (ok, full on push, or selected stack empty). A push, a refused request or an
// unused request code is answered from the idle state; a successful pop or
// peek is answered from the read state, after the memory's registered read.
// One request is handled at a time. The result sits in an output
// register, so a new request transfer is taken while the previous result is
// being taken in the same cycle; while an earlier result is still held and
// unclaimed, in_ready stays low. The memory has no reset and needs no clearing
// pass, since only slots written by an earlier push are ever read.
// ----------------------------------------------------------------------------
module two_stacks_shared_array_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tss_pkg::tss_kind_t in_kind,
  input  logic               in_which_stack,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_read_value,
  output tss_pkg::tss_status_t out_status
);
  import tss_pkg::*;

  // Address width covers the slots; count width also holds DEPTH itself.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tss_mem_req_t mem_req;
  tss_out_ctl_t out_ctl;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_rdata;
  logic          out_free;

  logic               out_valid_r;
  logic signed [31:0] out_read_value_r;
  tss_status_t        out_status_r;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ready;

  tss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (in_kind),
    .which_stack (in_which_stack),
    .out_free    (out_free),
    .mem_req     (mem_req),
    .mem_addr    (mem_addr),
    .out_ctl     (out_ctl)
  );

  tss_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .re      (mem_req.re),
    .addr    (mem_addr),
    .wdata   (in_push_value),
    .rdata_r (mem_rdata)
  );

  // Result register: loaded by the controller, cleared once transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; only pop and peek results carry memory data.
  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      out_read_value_r <= out_ctl.from_mem ? mem_rdata : 32'sd0;
      out_status_r     <= out_ctl.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

endmodule

/* rtl/tss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two stacks in one store: shared word memory
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

/* rtl/tss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two stacks in one store: controller
// Holds both stack counts, decodes requests into memory accesses and steers
// the result register.
// ----------------------------------------------------------------------------
module tss_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tss_pkg::tss_kind_t    kind,
  input  logic                  which_stack,
  input  logic                  out_free,
  output tss_pkg::tss_mem_req_t mem_req,
  output logic [AW-1:0]         mem_addr,
  output tss_pkg::tss_out_ctl_t out_ctl
);
  import tss_pkg::*;

  tss_state_t    state_r, state_nxt;
  logic [CW-1:0] lower_r, lower_nxt;
  logic [CW-1:0] upper_r, upper_nxt;
  logic [CW:0]   used;
  logic [CW-1:0] sel_cnt;
  logic [CW-1:0] up_push_slot;
  logic [CW-1:0] up_top_slot;
  logic [CW-1:0] lo_top_slot;
  logic          accept;

  assign used         = {1'b0, lower_r} + {1'b0, upper_r};
  assign sel_cnt      = which_stack ? upper_r : lower_r;
  assign up_push_slot = CW'(DEPTH) - upper_r - CW'(1);
  assign up_top_slot  = CW'(DEPTH) - upper_r;
  assign lo_top_slot  = lower_r - CW'(1);
  assign in_ready     = (state_r == S_IDLE) && out_free;
  assign accept       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lower_r <= '0;
      upper_r <= '0;
    end else begin
      state_r <= state_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    lower_nxt       = lower_r;
    upper_nxt       = upper_r;
    mem_req         = '0;
    mem_addr        = '0;
    out_ctl         = '0;
    out_ctl.status  = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (kind == KIND_PUSH) begin
            out_ctl.load = 1'b1;
            if (used >= (CW+1)'(DEPTH)) begin
              out_ctl.status = STAT_FULL;
            end else if (which_stack) begin
              mem_req.we = 1'b1;
              mem_addr   = up_push_slot[AW-1:0];
              upper_nxt  = upper_r + CW'(1);
            end else begin
              mem_req.we = 1'b1;
              mem_addr   = lower_r[AW-1:0];
              lower_nxt  = lower_r + CW'(1);
            end
          end else if (kind == KIND_POP || kind == KIND_PEEK) begin
            if (sel_cnt == '0) begin
              out_ctl.load   = 1'b1;
              out_ctl.status = STAT_EMPTY;
            end else begin
              mem_req.re = 1'b1;
              mem_addr   = which_stack ? up_top_slot[AW-1:0] : lo_top_slot[AW-1:0];
              state_nxt  = S_READ;
              if (kind == KIND_POP) begin
                if (which_stack) begin
                  upper_nxt = upper_r - CW'(1);
                end else begin
                  lower_nxt = lower_r - CW'(1);
                end
              end
            end
          end else begin
            // Unused request code: answered as ok, no state change.
            out_ctl.load = 1'b1;
          end
        end
      end
      S_READ: begin
        out_ctl.load     = 1'b1;
        out_ctl.from_mem = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two stacks in one store: port checker
// Concurrent assertions on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module tss_port_assertions (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input tss_pkg::tss_kind_t   in_kind,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [31:0]   out_read_value,
  input tss_pkg::tss_status_t out_status
);
  import tss_pkg::*;

  // A held result keeps its payload until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status))
    else $error("result changed while stalled");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_FULL
      || out_status == STAT_EMPTY))
    else $error("undefined status code");

  // Refused requests return a zero value.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_read_value == 32'sd0)
    else $error("refused request returned data");

  // A push is answered in the next cycle with a zero value.
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_PUSH |=> out_valid
      && out_read_value == 32'sd0 && out_status != STAT_EMPTY)
    else $error("push result wrong or late");

endmodule

bind two_stacks_shared_array_unit tss_port_assertions u_tss_port_assertions (.*);
